[hw/rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only outside reset
`define JSC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define JSC_ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/jsc_pkg.sv]
// package with payload types, codes and sizes of the json syntax checker
package jsc_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int MAXD_W      = 7;
  localparam int CMP_W       = (CNT_W > MAXD_W) ? CNT_W : MAXD_W;
  localparam int MODE_W      = 2;
  localparam int ST_W        = 5;
  localparam int CLS_W       = 5;
  localparam int ACT_W       = 4;

  localparam logic [MAXD_W-1:0] MAX_DEPTH_RST = MAXD_W'(64);

  // request types
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_END  = 1'b1;

  // nesting modes
  localparam logic [MODE_W-1:0] M_ARRAY  = 2'd0;
  localparam logic [MODE_W-1:0] M_DONE   = 2'd1;
  localparam logic [MODE_W-1:0] M_KEY    = 2'd2;
  localparam logic [MODE_W-1:0] M_OBJECT = 2'd3;

  // parser states
  localparam logic [ST_W-1:0] P_GO = 5'd0;
  localparam logic [ST_W-1:0] P_OK = 5'd1;
  localparam logic [ST_W-1:0] P_OB = 5'd2;
  localparam logic [ST_W-1:0] P_KE = 5'd3;
  localparam logic [ST_W-1:0] P_CO = 5'd4;
  localparam logic [ST_W-1:0] P_VA = 5'd5;
  localparam logic [ST_W-1:0] P_AR = 5'd6;
  localparam logic [ST_W-1:0] P_ST = 5'd7;
  localparam logic [ST_W-1:0] P_ES = 5'd8;
  localparam logic [ST_W-1:0] P_U1 = 5'd9;
  localparam logic [ST_W-1:0] P_U2 = 5'd10;
  localparam logic [ST_W-1:0] P_U3 = 5'd11;
  localparam logic [ST_W-1:0] P_U4 = 5'd12;
  localparam logic [ST_W-1:0] P_MI = 5'd13;
  localparam logic [ST_W-1:0] P_ZE = 5'd14;
  localparam logic [ST_W-1:0] P_IN = 5'd15;
  localparam logic [ST_W-1:0] P_FR = 5'd16;
  localparam logic [ST_W-1:0] P_FS = 5'd17;
  localparam logic [ST_W-1:0] P_E1 = 5'd18;
  localparam logic [ST_W-1:0] P_E2 = 5'd19;
  localparam logic [ST_W-1:0] P_E3 = 5'd20;
  localparam logic [ST_W-1:0] P_T1 = 5'd21;
  localparam logic [ST_W-1:0] P_T2 = 5'd22;
  localparam logic [ST_W-1:0] P_T3 = 5'd23;
  localparam logic [ST_W-1:0] P_F1 = 5'd24;
  localparam logic [ST_W-1:0] P_F2 = 5'd25;
  localparam logic [ST_W-1:0] P_F3 = 5'd26;
  localparam logic [ST_W-1:0] P_F4 = 5'd27;
  localparam logic [ST_W-1:0] P_N1 = 5'd28;
  localparam logic [ST_W-1:0] P_N2 = 5'd29;
  localparam logic [ST_W-1:0] P_N3 = 5'd30;

  // actions of the transition table
  localparam logic [ACT_W-1:0] A_GOTO      = 4'd0;
  localparam logic [ACT_W-1:0] A_ERR       = 4'd1;
  localparam logic [ACT_W-1:0] A_CLOSE_EOB = 4'd2;
  localparam logic [ACT_W-1:0] A_CLOSE_OBJ = 4'd3;
  localparam logic [ACT_W-1:0] A_CLOSE_ARR = 4'd4;
  localparam logic [ACT_W-1:0] A_OPEN_OBJ  = 4'd5;
  localparam logic [ACT_W-1:0] A_OPEN_ARR  = 4'd6;
  localparam logic [ACT_W-1:0] A_END_QUOTE = 4'd7;
  localparam logic [ACT_W-1:0] A_COMMA     = 4'd8;
  localparam logic [ACT_W-1:0] A_COLON     = 4'd9;

  typedef struct packed {
    logic       req_type;
    logic [7:0] char_byte;
  } in_t;

  typedef struct packed {
    logic ok;
    logic is_verdict;
  } out_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic [ST_W-1:0]  nxt_st;
  } dec_t;

endpackage

[hw/rtl/jsc_decode.sv]
// character classifier and state transition table of the checker
module jsc_decode (
  input  logic [jsc_pkg::ST_W-1:0] state,
  input  logic [7:0]               char_byte,
  output jsc_pkg::dec_t            dec
);
  import jsc_pkg::*;

  localparam logic [CLS_W-1:0] K_SPACE = 5'd0;
  localparam logic [CLS_W-1:0] K_WHITE = 5'd1;
  localparam logic [CLS_W-1:0] K_LCURB = 5'd2;
  localparam logic [CLS_W-1:0] K_RCURB = 5'd3;
  localparam logic [CLS_W-1:0] K_LSQRB = 5'd4;
  localparam logic [CLS_W-1:0] K_RSQRB = 5'd5;
  localparam logic [CLS_W-1:0] K_COLON = 5'd6;
  localparam logic [CLS_W-1:0] K_COMMA = 5'd7;
  localparam logic [CLS_W-1:0] K_QUOTE = 5'd8;
  localparam logic [CLS_W-1:0] K_BACKS = 5'd9;
  localparam logic [CLS_W-1:0] K_SLASH = 5'd10;
  localparam logic [CLS_W-1:0] K_PLUS  = 5'd11;
  localparam logic [CLS_W-1:0] K_MINUS = 5'd12;
  localparam logic [CLS_W-1:0] K_POINT = 5'd13;
  localparam logic [CLS_W-1:0] K_ZERO  = 5'd14;
  localparam logic [CLS_W-1:0] K_DIGIT = 5'd15;
  localparam logic [CLS_W-1:0] K_LA    = 5'd16;
  localparam logic [CLS_W-1:0] K_LB    = 5'd17;
  localparam logic [CLS_W-1:0] K_LC    = 5'd18;
  localparam logic [CLS_W-1:0] K_LD    = 5'd19;
  localparam logic [CLS_W-1:0] K_LE    = 5'd20;
  localparam logic [CLS_W-1:0] K_LF    = 5'd21;
  localparam logic [CLS_W-1:0] K_LL    = 5'd22;
  localparam logic [CLS_W-1:0] K_LN    = 5'd23;
  localparam logic [CLS_W-1:0] K_LR    = 5'd24;
  localparam logic [CLS_W-1:0] K_LS    = 5'd25;
  localparam logic [CLS_W-1:0] K_LT    = 5'd26;
  localparam logic [CLS_W-1:0] K_LU    = 5'd27;
  localparam logic [CLS_W-1:0] K_UHEX  = 5'd28;
  localparam logic [CLS_W-1:0] K_UE    = 5'd29;
  localparam logic [CLS_W-1:0] K_OTHER = 5'd30;
  localparam logic [CLS_W-1:0] K_BAD   = 5'd31;

  function automatic logic [CLS_W-1:0] classify(input logic [7:0] b);
    logic [CLS_W-1:0] c;
    c = K_OTHER;
    if (b[7]) begin
      c = K_OTHER;
    end else if (b == 8'd9 || b == 8'd10 || b == 8'd13) begin
      c = K_WHITE;
    end else if (b < 8'd32) begin
      c = K_BAD;
    end else if (b inside {[8'd49:8'd57]}) begin
      c = K_DIGIT;
    end else begin
      case (b)
        8'd32:  c = K_SPACE;
        8'd123: c = K_LCURB;
        8'd125: c = K_RCURB;
        8'd91:  c = K_LSQRB;
        8'd93:  c = K_RSQRB;
        8'd58:  c = K_COLON;
        8'd44:  c = K_COMMA;
        8'd34:  c = K_QUOTE;
        8'd92:  c = K_BACKS;
        8'd47:  c = K_SLASH;
        8'd43:  c = K_PLUS;
        8'd45:  c = K_MINUS;
        8'd46:  c = K_POINT;
        8'd48:  c = K_ZERO;
        8'd97:  c = K_LA;
        8'd98:  c = K_LB;
        8'd99:  c = K_LC;
        8'd100: c = K_LD;
        8'd101: c = K_LE;
        8'd102: c = K_LF;
        8'd108: c = K_LL;
        8'd110: c = K_LN;
        8'd114: c = K_LR;
        8'd115: c = K_LS;
        8'd116: c = K_LT;
        8'd117: c = K_LU;
        8'd65, 8'd66, 8'd67, 8'd68, 8'd70: c = K_UHEX;
        8'd69:  c = K_UE;
        default: c = K_OTHER;
      endcase
    end
    return c;
  endfunction

  function automatic dec_t go(input logic [ST_W-1:0] s);
    return '{act: A_GOTO, nxt_st: s};
  endfunction

  function automatic dec_t act(input logic [ACT_W-1:0] a);
    return '{act: a, nxt_st: P_GO};
  endfunction

  function automatic dec_t value_start(input logic [CLS_W-1:0] c);
    dec_t d;
    case (c)
      K_LCURB: d = act(A_OPEN_OBJ);
      K_LSQRB: d = act(A_OPEN_ARR);
      K_QUOTE: d = go(P_ST);
      K_MINUS: d = go(P_MI);
      K_ZERO:  d = go(P_ZE);
      K_DIGIT: d = go(P_IN);
      K_LF:    d = go(P_F1);
      K_LN:    d = go(P_N1);
      K_LT:    d = go(P_T1);
      default: d = act(A_ERR);
    endcase
    return d;
  endfunction

  logic [CLS_W-1:0] cls;
  logic blank, digit, hex, expo, num_end;

  assign cls     = classify(char_byte);
  assign blank   = (cls == K_SPACE) || (cls == K_WHITE);
  assign digit   = (cls == K_ZERO) || (cls == K_DIGIT);
  assign hex     = cls inside {[K_ZERO:K_LF], K_UHEX, K_UE};
  assign expo    = (cls == K_LE) || (cls == K_UE);
  assign num_end = state inside {P_ZE, P_IN, P_FS, P_E3};

  always_comb begin
    dec = act(A_ERR);
    if (cls == K_BAD) begin
      dec = act(A_ERR);
    end else if (num_end && blank) begin
      dec = go(P_OK);
    end else if (num_end && cls == K_RCURB) begin
      dec = act(A_CLOSE_OBJ);
    end else if (num_end && cls == K_RSQRB) begin
      dec = act(A_CLOSE_ARR);
    end else if (num_end && cls == K_COMMA) begin
      dec = act(A_COMMA);
    end else begin
      case (state)
        P_GO: begin
          if (blank)               dec = go(P_GO);
          else if (cls == K_LCURB) dec = act(A_OPEN_OBJ);
          else if (cls == K_LSQRB) dec = act(A_OPEN_ARR);
        end
        P_OK: begin
          if (blank)               dec = go(P_OK);
          else if (cls == K_RCURB) dec = act(A_CLOSE_OBJ);
          else if (cls == K_RSQRB) dec = act(A_CLOSE_ARR);
          else if (cls == K_COMMA) dec = act(A_COMMA);
        end
        P_OB: begin
          if (blank)               dec = go(P_OB);
          else if (cls == K_RCURB) dec = act(A_CLOSE_EOB);
          else if (cls == K_QUOTE) dec = go(P_ST);
        end
        P_KE: begin
          if (blank)               dec = go(P_KE);
          else if (cls == K_QUOTE) dec = go(P_ST);
        end
        P_CO: begin
          if (blank)               dec = go(P_CO);
          else if (cls == K_COLON) dec = act(A_COLON);
        end
        P_VA: begin
          if (blank) dec = go(P_VA);
          else       dec = value_start(cls);
        end
        P_AR: begin
          if (blank)               dec = go(P_AR);
          else if (cls == K_RSQRB) dec = act(A_CLOSE_ARR);
          else                     dec = value_start(cls);
        end
        P_ST: begin
          if (cls == K_WHITE)      dec = act(A_ERR);
          else if (cls == K_QUOTE) dec = act(A_END_QUOTE);
          else if (cls == K_BACKS) dec = go(P_ES);
          else                     dec = go(P_ST);
        end
        P_ES: begin
          if (cls inside {K_QUOTE, K_BACKS, K_SLASH, K_LB, K_LF, K_LN, K_LR, K_LT})
            dec = go(P_ST);
          else if (cls == K_LU)
            dec = go(P_U1);
        end
        P_U1: if (hex) dec = go(P_U2);
        P_U2: if (hex) dec = go(P_U3);
        P_U3: if (hex) dec = go(P_U4);
        P_U4: if (hex) dec = go(P_ST);
        P_MI: begin
          if (cls == K_ZERO)       dec = go(P_ZE);
          else if (cls == K_DIGIT) dec = go(P_IN);
        end
        P_ZE: begin
          if (cls == K_POINT) dec = go(P_FR);
          else if (expo)      dec = go(P_E1);
        end
        P_IN: begin
          if (digit)               dec = go(P_IN);
          else if (cls == K_POINT) dec = go(P_FR);
          else if (expo)           dec = go(P_E1);
        end
        P_FR: if (digit) dec = go(P_FS);
        P_FS: begin
          if (digit)     dec = go(P_FS);
          else if (expo) dec = go(P_E1);
        end
        P_E1: begin
          if (cls == K_PLUS || cls == K_MINUS) dec = go(P_E2);
          else if (digit)                      dec = go(P_E3);
        end
        P_E2: if (digit) dec = go(P_E3);
        P_E3: if (digit) dec = go(P_E3);
        P_T1: if (cls == K_LR) dec = go(P_T2);
        P_T2: if (cls == K_LU) dec = go(P_T3);
        P_T3: if (cls == K_LE) dec = go(P_OK);
        P_F1: if (cls == K_LA) dec = go(P_F2);
        P_F2: if (cls == K_LL) dec = go(P_F3);
        P_F3: if (cls == K_LS) dec = go(P_F4);
        P_F4: if (cls == K_LE) dec = go(P_OK);
        P_N1: if (cls == K_LU) dec = go(P_N2);
        P_N2: if (cls == K_LL) dec = go(P_N3);
        P_N3: if (cls == K_LL) dec = go(P_OK);
        default: dec = act(A_ERR);
      endcase
    end
  end

endmodule

[hw/rtl/jsc_stack_ram.sv]
// single-port-write, one-read synchronous ram for the nesting stack
module jsc_stack_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/json_syntax_checker.sv]
// json syntax checker top level: parser control, stack top cache and output buffer
//
// Checks JSON text one byte per request. in_data.req_type = 0 carries a text
// byte, 1 marks end of document. Every request gives exactly one result:
// out_data.ok is 1 while the text is valid so far (byte) or when the whole
// document is accepted (end of document, with out_data.is_verdict = 1).
// An end of document restarts the checker; max_depth (cfg_we / cfg_data)
// is kept and may be written between requests.
// Results are registered in the output register; one request is taken every
// cycle while in_stall is low. The top of the nesting stack sits in a register
// and the entry below it is fetched from the stack ram in the cycle before it
// is needed, so a push, pop or replace completes in the cycle of its byte.
// Reset (synchronous, rst_n low) loads the start state, an empty document
// and max_depth = 64; the stack ram needs no clearing pass since only
// entries below the fill count are read.
// When the receiver stalls, a second result is held in a skid register and
// in_stall rises only once both output registers are full.
module json_syntax_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  jsc_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output jsc_pkg::out_t               out_data,
  input  logic                        cfg_we,
  input  logic [jsc_pkg::MAXD_W-1:0]  cfg_data
);
  import jsc_pkg::*;

  logic [MAXD_W-1:0] max_depth_r;
  logic [ST_W-1:0]   state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [MODE_W-1:0] top_r, top_nxt;
  logic              sticky_r, sticky_nxt;

  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  out_t              skid_r, skid_nxt;

  dec_t              dec;
  logic              acc;
  logic              take;
  logic              restart;
  logic              accept_doc;
  logic              fail;
  logic [MODE_W-1:0] top_eff;
  logic [MODE_W-1:0] below;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_p1;
  logic [CNT_W-1:0]  rd_cnt;
  logic              push_ok;
  logic              repl_ok;
  out_t              res;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [MODE_W-1:0] wdata;
  logic [ADDR_W-1:0] raddr;

  jsc_decode u_decode (
    .state     (state_r),
    .char_byte (in_data.char_byte),
    .dec       (dec)
  );

  jsc_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (MODE_W)
  ) u_stack_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (below)
  );

  assign in_stall = skid_valid_r;
  assign acc      = in_valid && !in_stall;
  assign take     = out_valid_r && !out_stall;

  assign top_eff = (count_r == '0) ? M_DONE : top_r;
  assign cnt_m1  = count_r - CNT_W'(1);
  assign cnt_p1  = count_r + CNT_W'(1);
  assign push_ok = (CMP_W'(count_r) < CMP_W'(max_depth_r)) &&
                   (count_r < CNT_W'(STACK_DEPTH));
  // pop then push on the same slot: the push sees the count one lower
  assign repl_ok = (count_r != '0) &&
                   (CMP_W'(cnt_m1) < CMP_W'(max_depth_r)) &&
                   (cnt_m1 < CNT_W'(STACK_DEPTH));

  assign accept_doc = sticky_r && (state_r == P_OK) && (count_r != '0) &&
                      (top_r == M_DONE);
  assign restart    = !rst_n || (acc && in_data.req_type == REQ_END);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    top_nxt    = top_r;
    sticky_nxt = sticky_r;
    fail       = 1'b0;
    we         = 1'b0;
    waddr      = count_r[ADDR_W-1:0];
    wdata      = M_KEY;
    res        = '{ok: sticky_r, is_verdict: 1'b0};

    if (restart) begin
      state_nxt  = P_GO;
      count_nxt  = CNT_W'(1);
      top_nxt    = M_DONE;
      sticky_nxt = 1'b1;
      we         = 1'b1;
      waddr      = '0;
      wdata      = M_DONE;
      res        = '{ok: accept_doc, is_verdict: 1'b1};
    end else if (acc && sticky_r) begin
      case (dec.act)
        A_GOTO: state_nxt = dec.nxt_st;
        A_CLOSE_EOB, A_CLOSE_OBJ, A_CLOSE_ARR: begin
          if (count_r != '0 &&
              ((dec.act == A_CLOSE_EOB && top_r == M_KEY) ||
               (dec.act == A_CLOSE_OBJ && top_r == M_OBJECT) ||
               (dec.act == A_CLOSE_ARR && top_r == M_ARRAY))) begin
            count_nxt = cnt_m1;
            top_nxt   = below;
            state_nxt = P_OK;
          end else begin
            fail = 1'b1;
          end
        end
        A_OPEN_OBJ, A_OPEN_ARR: begin
          if (push_ok) begin
            we        = 1'b1;
            waddr     = count_r[ADDR_W-1:0];
            wdata     = (dec.act == A_OPEN_OBJ) ? M_KEY : M_ARRAY;
            top_nxt   = wdata;
            count_nxt = cnt_p1;
            state_nxt = (dec.act == A_OPEN_OBJ) ? P_OB : P_AR;
          end else begin
            fail = 1'b1;
          end
        end
        A_END_QUOTE: begin
          case (top_eff)
            M_KEY:             state_nxt = P_CO;
            M_ARRAY, M_OBJECT: state_nxt = P_OK;
            default:           fail = 1'b1;
          endcase
        end
        A_COMMA: begin
          if (top_eff == M_ARRAY) begin
            state_nxt = P_VA;
          end else if (top_eff == M_OBJECT && repl_ok) begin
            we        = 1'b1;
            waddr     = cnt_m1[ADDR_W-1:0];
            wdata     = M_KEY;
            top_nxt   = M_KEY;
            state_nxt = P_KE;
          end else begin
            fail = 1'b1;
          end
        end
        A_COLON: begin
          if (top_eff == M_KEY && repl_ok) begin
            we        = 1'b1;
            waddr     = cnt_m1[ADDR_W-1:0];
            wdata     = M_OBJECT;
            top_nxt   = M_OBJECT;
            state_nxt = P_VA;
          end else begin
            fail = 1'b1;
          end
        end
        default: fail = 1'b1;
      endcase
      if (fail) begin
        sticky_nxt = 1'b0;
      end
      res = '{ok: sticky_nxt, is_verdict: 1'b0};
    end
  end

  // fetch the entry that will sit below the next top; a write never hits it
  assign rd_cnt = count_nxt - CNT_W'(2);
  assign raddr  = rd_cnt[ADDR_W-1:0];

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (take || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = acc;
        out_nxt       = res;
      end
    end else if (acc) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_depth_r  <= MAX_DEPTH_RST;
      state_r      <= P_GO;
      count_r      <= CNT_W'(1);
      top_r        <= M_DONE;
      sticky_r     <= 1'b1;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_depth_r <= cfg_data;
      end
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      top_r        <= top_nxt;
      sticky_r     <= sticky_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[hw/rtl/jsc_checker.sv]
// port-level assertions for the json syntax checker and their bind
`include "assert_macros.svh"

module jsc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input jsc_pkg::in_t                in_data,
  input logic                        out_valid,
  input logic                        out_stall,
  input jsc_pkg::out_t               out_data,
  input logic                        cfg_we,
  input logic [jsc_pkg::MAXD_W-1:0]  cfg_data
);
  import jsc_pkg::*;

  logic rej_r, rej_nxt;
  logic out_take;
  logic unused_in;

  assign out_take  = out_valid && !out_stall;
  assign unused_in = in_valid ^ (^in_data) ^ cfg_we ^ (^cfg_data);

  // a rejected byte taints every later result up to and including the verdict
  always_comb begin
    rej_nxt = rej_r;
    if (out_take && out_data.is_verdict) begin
      rej_nxt = 1'b0;
    end else if (out_take && !out_data.ok) begin
      rej_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rej_r <= 1'b0;
    end else begin
      rej_r <= rej_nxt;
    end
  end

  `JSC_ASSERT_ALL(a_rst_no_stall, clk, !rst_n |=> !in_stall, "in_stall high after reset")
  `JSC_ASSERT_ALL(a_rst_no_out, clk, !rst_n |=> !out_valid, "out_valid high after reset")
  `JSC_ASSERT(a_reject_sticky, clk, rst_n, out_valid && rej_r && !unused_in |-> !out_data.ok || unused_in, "ok after rejection")
  `JSC_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")

endmodule

bind json_syntax_checker jsc_checker u_jsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_we    (cfg_we),
  .cfg_data  (cfg_data)
);
